@@ design/csrp_pkg.sv @@
// ----------------------------------------------------------------------------
// csrp_pkg
// Shared types, constants and the byte packing function of the register
// planner.
// ----------------------------------------------------------------------------
`default_nettype none
package csrp_pkg;

   localparam int DIV_NUM_W = 46;
   localparam int DIV_DEN_W = 28;

   localparam logic [29:0] PLL_TARGET     = 30'd900000000;
   localparam logic [27:0] FREQ_MIN       = 28'd439454;
   localparam logic [27:0] FREQ_MAX       = 28'd150000000;
   localparam logic [7:0]  PLL_RESET_DATA = 8'hA0;
   localparam logic [17:0] P1_OFFSET      = 18'd512;
   localparam logic [4:0]  BEAT_LAST      = 5'd17;
   localparam logic [4:0]  BEAT_RESET     = 5'd16;

   localparam logic [2:0] CSR_XTAL      = 3'd0;
   localparam logic [2:0] CSR_PLL_BASE  = 3'd1;
   localparam logic [2:0] CSR_MS_BASE   = 3'd2;
   localparam logic [2:0] CSR_PLL_RESET = 3'd3;
   localparam logic [2:0] CSR_CLK_ADDR  = 3'd4;
   localparam logic [2:0] CSR_CLK_VALUE = 3'd5;

   typedef struct packed {
      logic [25:0] ref_clk_hz;
      logic [7:0]  pll_base_addr;
      logic [7:0]  ms_base_addr;
      logic [7:0]  pll_reset_addr;
      logic [7:0]  clk_ctrl_addr;
      logic [7:0]  clk_ctrl_value;
   } cfg_type;

   typedef struct packed {
      logic        bad;
      logic [2:0]  rcode;
      logic [17:0] pll_p1;
      logic [19:0] pll_p2;
      logic [17:0] ms_p1;
   } plan_type;

   function automatic logic [7:0] block_byte(input logic [2:0] idx, input logic [17:0] p1,
                                             input logic [19:0] p2, input logic [19:0] p3,
                                             input logic [2:0] rbits);
      logic [7:0] b;
      case (idx)
         3'd0: b = p3[15:8];
         3'd1: b = p3[7:0];
         3'd2: b = {1'b0, rbits, 2'b00, p1[17:16]};
         3'd3: b = p1[15:8];
         3'd4: b = p1[7:0];
         3'd5: b = {p3[19:16], p2[19:16]};
         3'd6: b = p2[15:8];
         default: b = p2[7:0];
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

@@ design/clock_synth_register_planner.sv @@
// ----------------------------------------------------------------------------
// clock_synth_register_planner
// Turns a wanted frequency and R divider code into clock chip register writes.
// ----------------------------------------------------------------------------
// Usage: a request beat on req_ carries frequency and r_div_code. Each good
// request gives 18 rsp_ beats (eight PLL bytes, eight output divider bytes,
// PLL reset, clock control), rsp_tlast on the final one. An out-of-range
// frequency, or a crystal of zero, gives one beat with rsp_tuser set.
// The planner runs three divisions on one shared bit-serial divider; the
// split of 128*b by c is a shift and add. A finished plan, good or
// refused, is written into the queue, and its first rsp_ beat turns valid
// once the writer has popped it into its own beat register. The writer
// then sends one beat per cycle while rsp_tready is high. The planner takes
// no new request until it has queued the plan of the last one.
// A two-entry plan queue lets the planner go on with the next request while
// the receiver stalls; once the queue is full the planner holds its finished
// plan and req_tready stays low until the writer frees a slot. Reset clears
// all control state and loads the register defaults; csr_ writes take effect
// at once and belong in idle time.
// ----------------------------------------------------------------------------
`default_nettype none
module clock_synth_register_planner
   import csrp_pkg::*;
#(
   parameter int FRAC_BITS = 20
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // frequency[27:0], r_div_code[30:28]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // reg_addr[7:0], reg_data[15:8]
   output logic             rsp_tlast,
   output logic             rsp_tuser,   // bad_request
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [25:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       push, q_full, q_empty, pop;
   plan_type   push_plan, q_head;
   logic [7:0] out_addr, out_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_XTAL:      cfg_in.ref_clk_hz     = csr_wdata;
            CSR_PLL_BASE:  cfg_in.pll_base_addr  = csr_wdata[7:0];
            CSR_MS_BASE:   cfg_in.ms_base_addr   = csr_wdata[7:0];
            CSR_PLL_RESET: cfg_in.pll_reset_addr = csr_wdata[7:0];
            CSR_CLK_ADDR:  cfg_in.clk_ctrl_addr  = csr_wdata[7:0];
            CSR_CLK_VALUE: cfg_in.clk_ctrl_value = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_clk_hz     <= 26'd25000000;
         cfg_ff.pll_base_addr  <= 8'd26;
         cfg_ff.ms_base_addr   <= 8'd42;
         cfg_ff.pll_reset_addr <= 8'd177;
         cfg_ff.clk_ctrl_addr  <= 8'd16;
         cfg_ff.clk_ctrl_value <= 8'h4F;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   csrp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_freq   (req_tdata[27:0]),
      .in_rcode  (req_tdata[30:28]),
      .push      (push),
      .push_plan (push_plan),
      .q_full    (q_full)
   );

   csrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_plan (push_plan),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   csrp_emit #(.FRAC_BITS(FRAC_BITS)) u_emit (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_addr  (out_addr),
      .out_data  (out_data),
      .out_last  (rsp_tlast),
      .out_bad   (rsp_tuser)
   );

   assign rsp_tdata = {out_data, out_addr};

endmodule
`default_nettype wire

@@ design/csrp_div.sv @@
// ----------------------------------------------------------------------------
// csrp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module csrp_div
   import csrp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_NUM_W-1:0] numer,
   input  wire logic [DIV_DEN_W-1:0] denom,
   output logic                      done,
   output logic [DIV_NUM_W-1:0]      quotient,
   output logic [DIV_DEN_W-1:0]      remainder
);

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W+1:0] diff;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, den_ff};
   assign ge    = ~diff[DIV_DEN_W+1];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = 6'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         rem_in = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

@@ design/csrp_front.sv @@
// ----------------------------------------------------------------------------
// csrp_front
// Accepts requests, checks range and works out the divider and PLL plan.
// ----------------------------------------------------------------------------
`default_nettype none
module csrp_front
   import csrp_pkg::*;
#(
   parameter int FRAC_BITS = 20
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [27:0] in_freq,
   input  wire logic [2:0]  in_rcode,
   output logic             push,
   output plan_type         push_plan,
   input  wire logic        q_full
);

   localparam logic [19:0] DENOM = 20'((64'd1 << FRAC_BITS) - 64'd1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_D0   = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_D1   = 3'd3;
   localparam logic [2:0] S_MUL2 = 3'd4;
   localparam logic [2:0] S_D2   = 3'd5;
   localparam logic [2:0] S_D3   = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic                 wait_ff, wait_in;
   logic [27:0]          freq_ff, freq_in;
   logic [2:0]           rcode_ff, rcode_in;
   logic                 bad_ff, bad_in;
   logic [11:0]          dvd_ff, dvd_in;
   logic [45:0]          wide_ff, wide_in;
   logic [10:0]          mult_ff, mult_in;
   logic [25:0]          rem_ff, rem_in;
   logic [FRAC_BITS-1:0] num_ff, num_in;
   logic [6:0]           frac_ff, frac_in;
   logic [19:0]          p2_ff, p2_in;

   logic                 div_start, div_done;
   logic [DIV_NUM_W-1:0] div_numer, div_quo;
   logic [DIV_DEN_W-1:0] div_denom, div_rem;
   logic [39:0]          mul_w;
   logic [45:0]          mul2_w;
   logic [FRAC_BITS+6:0] fx_w;
   logic [FRAC_BITS:0]   fr0_w, fden_w;
   logic                 fr_ge;

   csrp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numer     (div_numer),
      .denom     (div_denom),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign mul_w  = dvd_ff * freq_ff;
   assign mul2_w = rem_ff * DENOM;

   // 128*b split by 2^k-1: high part plus low part, one correction step
   assign fx_w   = {num_ff, 7'd0};
   assign fden_w = {1'b0, {FRAC_BITS{1'b1}}};
   assign fr0_w  = {1'b0, fx_w[FRAC_BITS-1:0]} +
                   (FRAC_BITS+1)'(fx_w[FRAC_BITS+6:FRAC_BITS]);
   assign fr_ge  = (fr0_w >= fden_w);

   always_comb begin
      case (state_ff)
         S_D1, S_D2: begin
            div_numer = wide_ff;
            div_denom = {2'b00, cfg.ref_clk_hz};
         end
         default: begin
            div_numer = {16'd0, PLL_TARGET};
            div_denom = freq_ff;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      wait_in   = wait_ff;
      freq_in   = freq_ff;
      rcode_in  = rcode_ff;
      bad_in    = bad_ff;
      dvd_in    = dvd_ff;
      wide_in   = wide_ff;
      mult_in   = mult_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      frac_in   = frac_ff;
      p2_in     = p2_ff;
      div_start = 1'b0;
      push      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               freq_in  = in_freq;
               rcode_in = in_rcode;
               bad_in   = (in_freq < FREQ_MIN) || (in_freq > FREQ_MAX) ||
                          (cfg.ref_clk_hz == 26'd0);
               wait_in  = 1'b0;
               state_in = bad_in ? S_DONE : S_D0;
            end
         end
         S_MUL: begin
            wide_in  = {16'd0, mul_w[29:0]};
            state_in = S_D1;
         end
         S_MUL2: begin
            wide_in  = mul2_w;
            state_in = S_D2;
         end
         S_D3: begin
            frac_in  = fx_w[FRAC_BITS+6:FRAC_BITS] + {6'd0, fr_ge};
            p2_in    = 20'(fr_ge ? fr0_w - fden_w : fr0_w);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!q_full) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            if (!wait_ff) begin
               div_start = 1'b1;
               wait_in   = 1'b1;
            end else if (div_done) begin
               wait_in = 1'b0;
               case (state_ff)
                  S_D0: begin
                     dvd_in   = div_quo[11:0] & 12'hFFE;
                     state_in = S_MUL;
                  end
                  S_D1: begin
                     mult_in  = div_quo[10:0];
                     rem_in   = div_rem[25:0];
                     state_in = S_MUL2;
                  end
                  default: begin
                     num_in   = div_quo[FRAC_BITS-1:0];
                     state_in = S_D3;
                  end
               endcase
            end
         end
      endcase
   end

   assign in_ready         = (state_ff == S_IDLE);
   assign push_plan.bad    = bad_ff;
   assign push_plan.rcode  = rcode_ff;
   assign push_plan.pll_p1 = {mult_ff, 7'd0} + {11'd0, frac_ff} - P1_OFFSET;
   assign push_plan.pll_p2 = p2_ff;
   assign push_plan.ms_p1  = {dvd_ff[10:0], 7'd0} - P1_OFFSET;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
      freq_ff  <= freq_in;
      rcode_ff <= rcode_in;
      bad_ff   <= bad_in;
      dvd_ff   <= dvd_in;
      wide_ff  <= wide_in;
      mult_ff  <= mult_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      frac_ff  <= frac_in;
      p2_ff    <= p2_in;
   end

endmodule
`default_nettype wire

@@ design/csrp_queue.sv @@
// ----------------------------------------------------------------------------
// csrp_queue
// Two-entry queue of finished plans between the planner and the writer.
// ----------------------------------------------------------------------------
`default_nettype none
module csrp_queue
   import csrp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire plan_type push_plan,
   output logic          full,
   input  wire logic     pop,
   output logic          empty,
   output plan_type      head
);

   plan_type   mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_plan;
      end
   end

endmodule
`default_nettype wire

@@ design/csrp_emit.sv @@
// ----------------------------------------------------------------------------
// csrp_emit
// Takes plans from the queue and sends the register write beats in order.
// ----------------------------------------------------------------------------
`default_nettype none
module csrp_emit
   import csrp_pkg::*;
#(
   parameter int FRAC_BITS = 20
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     q_empty,
   input  wire plan_type q_head,
   output logic          pop,
   output logic          out_valid,
   input  wire logic     out_ready,
   output logic [7:0]    out_addr,
   output logic [7:0]    out_data,
   output logic          out_last,
   output logic          out_bad
);

   localparam logic [19:0] DENOM = 20'((64'd1 << FRAC_BITS) - 64'd1);

   plan_type   cur_ff, cur_in;
   logic       have_ff, have_in;
   logic [4:0] beat_ff, beat_in;
   logic       fire;

   assign fire     = have_ff && out_ready;
   assign out_last = cur_ff.bad || (beat_ff == BEAT_LAST);
   assign out_bad  = cur_ff.bad;
   assign pop      = !q_empty && (!have_ff || (fire && out_last));

   always_comb begin
      if (cur_ff.bad) begin
         out_addr = 8'd0;
         out_data = 8'd0;
      end else if (beat_ff[4:3] == 2'b00) begin
         out_addr = cfg.pll_base_addr + {5'd0, beat_ff[2:0]};
         out_data = block_byte(beat_ff[2:0], cur_ff.pll_p1, cur_ff.pll_p2, DENOM, 3'd0);
      end else if (beat_ff[4:3] == 2'b01) begin
         out_addr = cfg.ms_base_addr + {5'd0, beat_ff[2:0]};
         out_data = block_byte(beat_ff[2:0], cur_ff.ms_p1, 20'd0, 20'd1, cur_ff.rcode);
      end else if (beat_ff == BEAT_RESET) begin
         out_addr = cfg.pll_reset_addr;
         out_data = PLL_RESET_DATA;
      end else begin
         out_addr = cfg.clk_ctrl_addr;
         out_data = cfg.clk_ctrl_value;
      end
   end

   always_comb begin
      cur_in  = cur_ff;
      have_in = have_ff;
      beat_in = beat_ff;
      if (fire) begin
         beat_in = beat_ff + 5'd1;
         if (out_last) begin
            have_in = 1'b0;
         end
      end
      if (pop) begin
         cur_in  = q_head;
         have_in = 1'b1;
         beat_in = '0;
      end
   end

   assign out_valid = have_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         beat_ff <= '0;
      end else begin
         have_ff <= have_in;
         beat_ff <= beat_in;
      end
      cur_ff <= cur_in;
   end

endmodule
`default_nettype wire

@@ dv/clock_synth_register_planner_tb.sv @@
// ----------------------------------------------------------------------------
// clock_synth_register_planner_tb
// Drives frequency requests through the register planner and compares every
// register write beat against a local integer plan predictor, over several
// crystal and address settings, with random gaps and a long receiver stall.
// ----------------------------------------------------------------------------
`default_nettype none
module clock_synth_register_planner_tb
   import csrp_pkg::*;
;

   localparam int FRAC_BITS = 20;
   localparam int WATCH_LIMIT = 20000;

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] data;
      logic       last;
      logic       bad;
   } write_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [25:0] csr_wdata = '0;

   clock_synth_register_planner #(.FRAC_BITS(FRAC_BITS)) dut (.*);

   initial forever #2 clock = ~clock;

   // local copy of the register file
   logic [25:0] xtal_q;
   logic [7:0]  pll_base_q, ms_base_q, pll_rst_q, clk_addr_q, clk_val_q;

   write_beat_type planned_writes[$];
   int errors = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   int rx_gap = 0;
   bit stall_hold = 1'b0;

   task automatic push_write(input logic [7:0] a, input logic [7:0] d, input logic l,
                             input logic b);
      write_beat_type w;
      w.addr = a; w.data = d; w.last = l; w.bad = b;
      planned_writes.push_back(w);
   endtask

   task automatic push_block(input logic [7:0] base, input logic [17:0] p1,
                             input logic [19:0] p2, input logic [19:0] p3,
                             input logic [2:0] rc);
      logic [7:0] by[8];
      by[0] = p3[15:8];
      by[1] = p3[7:0];
      by[2] = {1'b0, rc, 2'b00, p1[17:16]};
      by[3] = p1[15:8];
      by[4] = p1[7:0];
      by[5] = {p3[19:16], p2[19:16]};
      by[6] = p2[15:8];
      by[7] = p2[7:0];
      for (int i = 0; i < 8; i++) push_write(base + 8'(i), by[i], 1'b0, 1'b0);
   endtask

   task automatic plan_frequency(input logic [27:0] freq, input logic [2:0] rc);
      logic [63:0] denom, divider, pll, mult, rem, num, frac, p1, p2;
      denom = (64'd1 << FRAC_BITS) - 1;
      if (freq < 28'd439454 || freq > 28'd150000000 || xtal_q == 0) begin
         push_write(8'd0, 8'd0, 1'b1, 1'b1);
         return;
      end
      divider = 64'd900000000 / freq;
      divider[0] = 1'b0;
      pll = divider * freq;
      mult = pll / xtal_q;
      rem = pll % xtal_q;
      num = (rem * denom) / xtal_q;
      frac = (128 * num) / denom;
      p1 = 128 * mult + frac - 512;
      p2 = (128 * num) % denom;
      push_block(pll_base_q, p1[17:0], p2[19:0], denom[19:0], 3'd0);
      p1 = 128 * divider - 512;
      push_block(ms_base_q, p1[17:0], 20'd0, 20'd1, rc);
      push_write(pll_rst_q, 8'hA0, 1'b0, 1'b0);
      push_write(clk_addr_q, clk_val_q, 1'b1, 1'b0);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [25:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_XTAL:      xtal_q = val;
         CSR_PLL_BASE:  pll_base_q = val[7:0];
         CSR_MS_BASE:   ms_base_q = val[7:0];
         CSR_PLL_RESET: pll_rst_q = val[7:0];
         CSR_CLK_ADDR:  clk_addr_q = val[7:0];
         CSR_CLK_VALUE: clk_val_q = val[7:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (planned_writes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // valid stays high across back-to-back beats and drops only before a gap or a drain
   task automatic send_request(input logic [27:0] freq, input logic [2:0] rc,
                               input bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, rc, freq};
      plan_frequency(freq, rc);
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [27:0] rand_freq();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return 28'($urandom_range(0, 439453));
      if (r < 8) return 28'($urandom_range(150000001, 268435455));
      if (r < 14) return 28'($urandom_range(439454, 460000));
      if (r < 20) return 28'($urandom_range(149000000, 150000000));
      return 28'($urandom_range(439454, 150000000));
   endfunction

   // receiver and checker
   always @(posedge clock) begin
      write_beat_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.addr = rsp_tdata[7:0]; got.data = rsp_tdata[15:8];
            got.last = rsp_tlast; got.bad = rsp_tuser;
            if (planned_writes.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected write beat %h", got);
            end else begin
               want = planned_writes.pop_front();
               if (got !== want) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display({"write mismatch: exp addr %h data %h last %b bad %b,",
                               " act addr %h data %h last %b bad %b"},
                              want.addr, want.data, want.last, want.bad,
                              got.addr, got.data, got.last, got.bad);
               end
            end
         end
         if (stall_hold) begin
            rsp_tready <= 1'b0;
         end else if (rx_gap > 0) begin
            rsp_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
         end else if ($urandom_range(0, 99) < 3) begin
            rsp_tready <= 1'b0;
            rx_gap <= $urandom_range(10, 60);
         end else begin
            rsp_tready <= ($urandom_range(0, 9) < 7);
         end
      end
   end

   // watchdog on cycles with no beat accepted either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("FAIL clock_synth_register_planner");
         $finish;
      end
   end

   task automatic test_directed();
      send_request(28'd439454, 3'd0, 0);
      send_request(28'd150000000, 3'd7, 0);
      send_request(28'd439453, 3'd1, 0);
      send_request(28'd150000001, 3'd2, 0);
      send_request(28'd0, 3'd3, 0);
      send_request(28'hFFFFFFF, 3'd4, 0);
      send_request(28'd10000000, 3'd5, 0);
      send_request(28'd100000000, 3'd6, 0);
      send_request(28'd14318180, 3'd2, 0);
      send_request(28'd7000000, 3'd1, 0);
      wait_drained();
   endtask

   task automatic test_config_sweep();
      csr_write(CSR_XTAL, 26'd10000000);
      csr_write(CSR_PLL_BASE, 26'd248);
      csr_write(CSR_MS_BASE, 26'd0);
      csr_write(CSR_PLL_RESET, 26'd255);
      csr_write(CSR_CLK_ADDR, 26'd0);
      csr_write(CSR_CLK_VALUE, 26'd255);
      repeat (60) send_request(rand_freq(), 3'($urandom), 1);
      wait_drained();
      csr_write(CSR_XTAL, 26'd40000000);
      csr_write(CSR_PLL_BASE, 26'd0);
      csr_write(CSR_MS_BASE, 26'd248);
      csr_write(CSR_PLL_RESET, 26'd0);
      csr_write(CSR_CLK_ADDR, 26'd255);
      csr_write(CSR_CLK_VALUE, 26'd0);
      repeat (60) send_request(rand_freq(), 3'($urandom), 1);
      wait_drained();
      // crystal outside its range: small, huge, then zero
      csr_write(CSR_XTAL, 26'd1000);
      repeat (10) send_request(rand_freq(), 3'($urandom), 1);
      wait_drained();
      csr_write(CSR_XTAL, 26'h3FFFFFF);
      repeat (10) send_request(rand_freq(), 3'($urandom), 1);
      wait_drained();
      csr_write(CSR_XTAL, 26'd0);
      repeat (8) send_request(rand_freq(), 3'($urandom), 1);
      wait_drained();
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(CSR_XTAL, 26'($urandom_range(10000000, 40000000)));
         csr_write(CSR_PLL_BASE, 26'($urandom_range(0, 248)));
         csr_write(CSR_MS_BASE, 26'($urandom_range(0, 248)));
         csr_write(CSR_PLL_RESET, 26'($urandom_range(0, 255)));
         csr_write(CSR_CLK_ADDR, 26'($urandom_range(0, 255)));
         csr_write(CSR_CLK_VALUE, 26'($urandom_range(0, 255)));
         repeat (50) send_request(rand_freq(), 3'($urandom), 1);
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      stall_hold = 1'b1;
      fork
         begin
            repeat (1500) @(posedge clock);
            stall_hold = 1'b0;
         end
         repeat (20) send_request(rand_freq(), 3'($urandom), 0);
      join
      wait_drained();
   endtask

   initial begin
      xtal_q = 26'd25000000; pll_base_q = 8'd26; ms_base_q = 8'd42;
      pll_rst_q = 8'd177; clk_addr_q = 8'd16; clk_val_q = 8'h4F;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_config_sweep();
      test_random_settings();
      if (errors == 0 && planned_writes.size() == 0)
         $display("PASS clock_synth_register_planner");
      else
         $display("FAIL clock_synth_register_planner");
      $finish;
   end

endmodule
`default_nettype wire
